>>> hw/rtl/pfp_pkg.sv
// ----------------------------------------------------------------------------
// pfp_pkg
// Shared widths and defaults for the plane-from-three-points pipeline.
// ----------------------------------------------------------------------------
package pfp_pkg;

    // defaults for the top-level parameters
    localparam int COORD_WIDTH_DEF      = 32;
    localparam int NORMAL_FRAC_BITS_DEF = 30;

    // fixed field widths on the stream ports
    localparam int FIELD_W  = 32;
    localparam int OFFSET_W = 48;
    localparam int IN_W     = 9 * FIELD_W;
    localparam int OUT_W    = 3 * FIELD_W + OFFSET_W;

    // normalized cross product magnitude, sum of squares and root widths
    localparam int NORM_W = 62;
    localparam int SUM_W  = 2 * NORM_W + 2;
    localparam int LEN_W  = NORM_W + 1;

endpackage

>>> hw/rtl/pfp_cross.sv
// ----------------------------------------------------------------------------
// pfp_cross
// Edge vectors and exact cross product, returned as sign and magnitude.
// Three register stages: differences, products, subtract and magnitude.
// ----------------------------------------------------------------------------
module pfp_cross #(
    parameter int CW = pfp_pkg::COORD_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        ce,
    input  logic                        in_valid,
    input  logic [pfp_pkg::IN_W-1:0]    in_data,
    output logic                        out_valid,
    output logic [2*CW+1:0]             out_mag [3],
    output logic [2:0]                  out_neg,
    output logic [3*CW-1:0]             out_p3
);
    import pfp_pkg::*;

    localparam int V_W   = CW + 1;
    localparam int PR_W  = 2 * V_W;
    localparam int MAG_W = 2 * CW + 2;

    logic [2:0]              vld_reg;
    logic signed [V_W-1:0]   v1_reg [3];
    logic signed [V_W-1:0]   v2_reg [3];
    logic signed [PR_W-1:0]  prod_reg [6];
    logic [3*CW-1:0]         p3_s1_reg, p3_s2_reg, p3_s3_reg;
    logic [MAG_W-1:0]        mag_reg [3];
    logic [2:0]              neg_reg;
    logic signed [CW-1:0]    pt [9];
    logic signed [MAG_W:0]   diff [3];

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    // take the low coordinate bits of each field
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            pt[i] = $signed(in_data[i*FIELD_W +: CW]);
        end
    end

    // stage 1: edge vectors v1 = p3 - p1, v2 = p2 - p1
    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < 3; k++) begin
                v1_reg[k] <= V_W'(pt[6+k]) - V_W'(pt[k]);
                v2_reg[k] <= V_W'(pt[3+k]) - V_W'(pt[k]);
            end
            p3_s1_reg <= {pt[8], pt[7], pt[6]};
        end
    end

    // stage 2: six partial products of the cross product
    always_ff @(posedge aclk) begin
        if (ce) begin
            prod_reg[0] <= PR_W'(v1_reg[1]) * PR_W'(v2_reg[2]);
            prod_reg[1] <= PR_W'(v1_reg[2]) * PR_W'(v2_reg[1]);
            prod_reg[2] <= PR_W'(v1_reg[2]) * PR_W'(v2_reg[0]);
            prod_reg[3] <= PR_W'(v1_reg[0]) * PR_W'(v2_reg[2]);
            prod_reg[4] <= PR_W'(v1_reg[0]) * PR_W'(v2_reg[1]);
            prod_reg[5] <= PR_W'(v1_reg[1]) * PR_W'(v2_reg[0]);
            p3_s2_reg   <= p3_s1_reg;
        end
    end

    // stage 3: subtract and split into sign and magnitude
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            diff[k] = (MAG_W+1)'(prod_reg[2*k]) - (MAG_W+1)'(prod_reg[2*k+1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < 3; k++) begin
                neg_reg[k] <= diff[k][MAG_W];
                mag_reg[k] <= diff[k][MAG_W] ? MAG_W'(-diff[k]) : MAG_W'(diff[k]);
            end
            p3_s3_reg <= p3_s2_reg;
        end
    end

    assign out_valid = vld_reg[2];
    assign out_mag   = mag_reg;
    assign out_neg   = neg_reg;
    assign out_p3    = p3_s3_reg;

endmodule

>>> hw/rtl/pfp_norm.sv
// ----------------------------------------------------------------------------
// pfp_norm
// Scales the three magnitudes to a common 62-bit frame and forms the sum of
// their squares. Five register stages.
// ----------------------------------------------------------------------------
module pfp_norm #(
    parameter int CW    = pfp_pkg::COORD_WIDTH_DEF,
    parameter int TAG_W = 1
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         ce,
    input  logic                         in_valid,
    input  logic [2*CW+1:0]              in_mag [3],
    input  logic [TAG_W-1:0]             in_tag,
    output logic                         out_valid,
    output logic [pfp_pkg::SUM_W-1:0]    out_sum,
    output logic [pfp_pkg::NORM_W-1:0]   out_c [3],
    output logic                         out_deg,
    output logic [TAG_W-1:0]             out_tag
);
    import pfp_pkg::*;

    localparam int MAG_W = 2 * CW + 2;
    localparam int BL_W  = $clog2(MAG_W + 1);
    localparam int SH_W  = MAG_W + NORM_W;
    localparam int HALF  = NORM_W / 2;
    localparam int SQ_W  = 2 * NORM_W;

    logic [4:0]          vld_reg;
    logic [MAG_W-1:0]    mag_reg [3];
    logic [BL_W-1:0]     bl_reg;
    logic [BL_W-1:0]     bl_next;
    logic [MAG_W-1:0]    orv;
    logic [SH_W-1:0]     sh [3];
    logic [NORM_W-1:0]   c2_reg [3], c3_reg [3], c4_reg [3], c5_reg [3];
    logic                deg2_reg, deg3_reg, deg4_reg, deg5_reg;
    logic [SQ_W-1:0]     hh_reg [3], hl_reg [3], ll_reg [3];
    logic [SQ_W-1:0]     sq_reg [3];
    logic [SUM_W-1:0]    sum_reg;
    logic [TAG_W-1:0]    tag1_reg, tag2_reg, tag3_reg, tag4_reg, tag5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    // stage 1: bit length of the largest magnitude
    always_comb begin
        orv     = in_mag[0] | in_mag[1] | in_mag[2];
        bl_next = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (orv[i]) begin
                bl_next = BL_W'(i + 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            mag_reg  <= in_mag;
            bl_reg   <= bl_next;
            tag1_reg <= in_tag;
        end
    end

    // stage 2: shift all three so the largest has exactly 62 bits
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (bl_reg > BL_W'(NORM_W)) begin
                sh[k] = SH_W'(mag_reg[k]) >> (bl_reg - BL_W'(NORM_W));
            end else begin
                sh[k] = SH_W'(mag_reg[k]) << (BL_W'(NORM_W) - bl_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < 3; k++) begin
                c2_reg[k] <= sh[k][NORM_W-1:0];
            end
            deg2_reg <= bl_reg == '0;
            tag2_reg <= tag1_reg;
        end
    end

    // stage 3: partial products of the squares on 31-bit halves
    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < 3; k++) begin
                hh_reg[k] <= SQ_W'(c2_reg[k][NORM_W-1:HALF]) * SQ_W'(c2_reg[k][NORM_W-1:HALF]);
                hl_reg[k] <= SQ_W'(c2_reg[k][NORM_W-1:HALF]) * SQ_W'(c2_reg[k][HALF-1:0]);
                ll_reg[k] <= SQ_W'(c2_reg[k][HALF-1:0]) * SQ_W'(c2_reg[k][HALF-1:0]);
            end
            c3_reg   <= c2_reg;
            deg3_reg <= deg2_reg;
            tag3_reg <= tag2_reg;
        end
    end

    // stage 4: assemble each square
    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < 3; k++) begin
                sq_reg[k] <= (hh_reg[k] << (2 * HALF)) + (hl_reg[k] << (HALF + 1)) + ll_reg[k];
            end
            c4_reg   <= c3_reg;
            deg4_reg <= deg3_reg;
            tag4_reg <= tag3_reg;
        end
    end

    // stage 5: sum of squares
    always_ff @(posedge aclk) begin
        if (ce) begin
            sum_reg  <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
            c5_reg   <= c4_reg;
            deg5_reg <= deg4_reg;
            tag5_reg <= tag4_reg;
        end
    end

    assign out_valid = vld_reg[4];
    assign out_sum   = sum_reg;
    assign out_c     = c5_reg;
    assign out_deg   = deg5_reg;
    assign out_tag   = tag5_reg;

endmodule

>>> hw/rtl/pfp_sqrt.sv
// ----------------------------------------------------------------------------
// pfp_sqrt
// Pipelined integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module pfp_sqrt #(
    parameter int TAG_W = 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        ce,
    input  logic                        in_valid,
    input  logic [pfp_pkg::SUM_W-1:0]   in_val,
    input  logic [TAG_W-1:0]            in_tag,
    output logic                        out_valid,
    output logic [pfp_pkg::LEN_W-1:0]   out_root,
    output logic [TAG_W-1:0]            out_tag
);
    import pfp_pkg::*;

    localparam int SQ_W = SUM_W + 2;

    logic [LEN_W-1:0]  vld_reg;
    logic [SQ_W-1:0]   rem_reg  [LEN_W];
    logic [LEN_W-1:0]  root_reg [LEN_W];
    logic [TAG_W-1:0]  tag_reg  [LEN_W];

    for (genvar k = 0; k < LEN_W; k++) begin : g_stage
        localparam int B = LEN_W - 1 - k;
        logic              vld_in;
        logic [SQ_W-1:0]   rem_in;
        logic [LEN_W-1:0]  root_in;
        logic [TAG_W-1:0]  tag_in;
        logic [SQ_W-1:0]   trial;
        logic              take;

        if (k == 0) begin : g_first
            assign vld_in  = in_valid;
            assign rem_in  = SQ_W'(in_val);
            assign root_in = '0;
            assign tag_in  = in_tag;
        end else begin : g_next
            assign vld_in  = vld_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign tag_in  = tag_reg[k-1];
        end

        // (r + 2^b)^2 - r^2 against the running remainder
        assign trial = (SQ_W'(root_in) << (B + 1)) | (SQ_W'(1) << (2 * B));
        assign take  = rem_in >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (ce) begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[k]  <= take ? rem_in - trial : rem_in;
                root_reg[k] <= take ? root_in | (LEN_W'(1) << B) : root_in;
                tag_reg[k]  <= tag_in;
            end
        end
    end

    assign out_valid = vld_reg[LEN_W-1];
    assign out_root  = root_reg[LEN_W-1];
    assign out_tag   = tag_reg[LEN_W-1];

endmodule

>>> hw/rtl/pfp_div.sv
// ----------------------------------------------------------------------------
// pfp_div
// Pipelined restoring divider for one normal component: round(c * 2^F / len),
// one quotient bit per stage plus a rounding stage.
// ----------------------------------------------------------------------------
module pfp_div #(
    parameter int F     = pfp_pkg::NORMAL_FRAC_BITS_DEF,
    parameter int TAG_W = 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        ce,
    input  logic                        in_valid,
    input  logic [pfp_pkg::NORM_W-1:0]  in_num,
    input  logic [pfp_pkg::LEN_W-1:0]   in_den,
    input  logic [TAG_W-1:0]            in_tag,
    output logic                        out_valid,
    output logic [F+1:0]                out_q,
    output logic [TAG_W-1:0]            out_tag
);
    import pfp_pkg::*;

    localparam int QN  = F + 1;
    localparam int R_W = LEN_W + F;
    localparam int Q_W = F + 2;

    logic [QN-1:0]     vld_reg;
    logic [R_W-1:0]    rem_reg [QN];
    logic [QN-1:0]     q_reg   [QN];
    logic [LEN_W-1:0]  den_reg [QN];
    logic [TAG_W-1:0]  tag_reg [QN];
    logic              vld_out_reg;
    logic [Q_W-1:0]    q_out_reg;
    logic [TAG_W-1:0]  tag_out_reg;
    logic [LEN_W-1:0]  rem_last;

    for (genvar k = 0; k < QN; k++) begin : g_stage
        localparam int B = QN - 1 - k;
        logic              vld_in;
        logic [R_W-1:0]    rem_in;
        logic [QN-1:0]     q_in;
        logic [LEN_W-1:0]  den_in;
        logic [TAG_W-1:0]  tag_in;
        logic [R_W-1:0]    dsh;
        logic              take;

        if (k == 0) begin : g_first
            assign vld_in = in_valid;
            assign rem_in = R_W'(in_num) << F;
            assign q_in   = '0;
            assign den_in = in_den;
            assign tag_in = in_tag;
        end else begin : g_next
            assign vld_in = vld_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign den_in = den_reg[k-1];
            assign tag_in = tag_reg[k-1];
        end

        assign dsh  = R_W'(den_in) << B;
        assign take = rem_in >= dsh;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (ce) begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[k] <= take ? rem_in - dsh : rem_in;
                q_reg[k]   <= take ? q_in | (QN'(1) << B) : q_in;
                den_reg[k] <= den_in;
                tag_reg[k] <= tag_in;
            end
        end
    end

    // rounding: ties away from zero
    assign rem_last = rem_reg[QN-1][LEN_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_out_reg <= 1'b0;
        end else if (ce) begin
            vld_out_reg <= vld_reg[QN-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            q_out_reg   <= Q_W'(q_reg[QN-1])
                         + Q_W'(rem_last >= den_reg[QN-1] - rem_last);
            tag_out_reg <= tag_reg[QN-1];
        end
    end

    assign out_valid = vld_out_reg;
    assign out_q     = q_out_reg;
    assign out_tag   = tag_out_reg;

endmodule

>>> hw/rtl/pfp_offset.sv
// ----------------------------------------------------------------------------
// pfp_offset
// Applies signs to the normal, forms d = -(n . p3) rounded to Q.16 and holds
// the result register. Three register stages.
// ----------------------------------------------------------------------------
module pfp_offset #(
    parameter int CW = pfp_pkg::COORD_WIDTH_DEF,
    parameter int F  = pfp_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          ce,
    input  logic                          in_valid,
    input  logic [F+1:0]                  in_q [3],
    input  logic [2:0]                    in_neg,
    input  logic                          in_deg,
    input  logic [3*CW-1:0]               in_p3,
    output logic                          out_valid,
    output logic [pfp_pkg::OUT_W-1:0]     out_data,
    output logic                          out_deg
);
    import pfp_pkg::*;

    localparam int N_W = F + 2;
    localparam int P_W = N_W + CW;
    localparam int D_W = P_W + 2;

    logic [2:0]              vld_reg;
    logic signed [N_W-1:0]   n_next [3];
    logic signed [N_W-1:0]   n1_reg [3], n2_reg [3];
    logic signed [P_W-1:0]   prod_reg [3];
    logic signed [D_W-1:0]   dot_reg;
    logic                    deg1_reg, deg2_reg, deg3_reg;
    logic [D_W-1:0]          dm;
    logic [D_W-1:0]          rnd;
    logic [OUT_W-1:0]        data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    // signed normal, zero when the points are collinear
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (in_deg) begin
                n_next[k] = '0;
            end else if (in_neg[k]) begin
                n_next[k] = -$signed(in_q[k]);
            end else begin
                n_next[k] = $signed(in_q[k]);
            end
        end
    end

    // stage 1: products n_i * p3_i
    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < 3; k++) begin
                prod_reg[k] <= P_W'(n_next[k]) * P_W'($signed(in_p3[k*CW +: CW]));
            end
            n1_reg   <= n_next;
            deg1_reg <= in_deg;
        end
    end

    // stage 2: dot product
    always_ff @(posedge aclk) begin
        if (ce) begin
            dot_reg  <= D_W'(prod_reg[0]) + D_W'(prod_reg[1]) + D_W'(prod_reg[2]);
            n2_reg   <= n1_reg;
            deg2_reg <= deg1_reg;
        end
    end

    // stage 3: round half away from zero, negate, result register
    always_comb begin
        dm  = dot_reg[D_W-1] ? D_W'(-dot_reg) : D_W'(dot_reg);
        rnd = (dm + (D_W'(1) << (F - 1))) >> F;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            data_reg[0*FIELD_W +: FIELD_W] <= FIELD_W'(n2_reg[0]);
            data_reg[1*FIELD_W +: FIELD_W] <= FIELD_W'(n2_reg[1]);
            data_reg[2*FIELD_W +: FIELD_W] <= FIELD_W'(n2_reg[2]);
            data_reg[3*FIELD_W +: OFFSET_W] <= dot_reg[D_W-1] ? OFFSET_W'(rnd)
                                                              : OFFSET_W'(-rnd);
            deg3_reg <= deg2_reg;
        end
    end

    assign out_valid = vld_reg[2];
    assign out_data  = data_reg;
    assign out_deg   = deg3_reg;

endmodule

>>> hw/rtl/plane_from_three_points.sv
// ----------------------------------------------------------------------------
// plane_from_three_points
// Plane through three points: unit normal in Q2.30 and offset d in Q32.16.
// ----------------------------------------------------------------------------
// One point triple is taken per clock while the pipeline is not stalled, and
// results leave in the same order. Each passes through the cross product,
// normalize and square, square root (one bit per stage), divider (one quotient
// bit per stage, then rounding) and offset stages. The whole pipeline advances
// together: while a result on the master side is not taken, every stage holds
// and s_axis_tready is low. Collinear or coincident points give a zero normal,
// zero offset and m_axis_tuser set.
module plane_from_three_points #(
    parameter int COORD_WIDTH      = pfp_pkg::COORD_WIDTH_DEF,
    parameter int NORMAL_FRAC_BITS = pfp_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z
    input  logic [pfp_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // normal_x, normal_y, normal_z, plane_offset
    output logic [pfp_pkg::OUT_W-1:0]   m_axis_tdata,
    // degenerate
    output logic [0:0]                  m_axis_tuser
);
    import pfp_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int F     = NORMAL_FRAC_BITS;
    localparam int MAG_W = 2 * CW + 2;
    localparam int T1_W  = 3 + 3 * CW;
    localparam int T2_W  = T1_W + 1 + 3 * NORM_W;

    logic                ce;
    logic                x_valid;
    logic [MAG_W-1:0]    x_mag [3];
    logic [2:0]          x_neg;
    logic [3*CW-1:0]     x_p3;
    logic                n_valid;
    logic [SUM_W-1:0]    n_sum;
    logic [NORM_W-1:0]   n_c [3];
    logic                n_deg;
    logic [T1_W-1:0]     n_tag;
    logic                r_valid;
    logic [LEN_W-1:0]    r_root;
    logic [T2_W-1:0]     r_tag;
    logic                d_valid;
    logic [F+1:0]        d_q [3];
    logic [T1_W:0]       d_tag0;
    logic [0:0]          d_tag1, d_tag2;
    logic                o_deg;

    // one enable for the whole pipeline: move when the output slot is free
    assign ce            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = ce;

    pfp_cross #(.CW(CW)) u_cross (
        .aclk, .aresetn, .ce,
        .in_valid (s_axis_tvalid),
        .in_data  (s_axis_tdata),
        .out_valid(x_valid),
        .out_mag  (x_mag),
        .out_neg  (x_neg),
        .out_p3   (x_p3)
    );

    pfp_norm #(.CW(CW), .TAG_W(T1_W)) u_norm (
        .aclk, .aresetn, .ce,
        .in_valid (x_valid),
        .in_mag   (x_mag),
        .in_tag   ({x_neg, x_p3}),
        .out_valid(n_valid),
        .out_sum  (n_sum),
        .out_c    (n_c),
        .out_deg  (n_deg),
        .out_tag  (n_tag)
    );

    pfp_sqrt #(.TAG_W(T2_W)) u_sqrt (
        .aclk, .aresetn, .ce,
        .in_valid (n_valid),
        .in_val   (n_sum),
        .in_tag   ({n_c[2], n_c[1], n_c[0], n_deg, n_tag}),
        .out_valid(r_valid),
        .out_root (r_root),
        .out_tag  (r_tag)
    );

    // three divider lanes; lane 0 carries the sideband
    pfp_div #(.F(F), .TAG_W(T1_W + 1)) u_div0 (
        .aclk, .aresetn, .ce,
        .in_valid (r_valid),
        .in_num   (r_tag[T1_W+1 +: NORM_W]),
        .in_den   (r_root),
        .in_tag   (r_tag[T1_W:0]),
        .out_valid(d_valid),
        .out_q    (d_q[0]),
        .out_tag  (d_tag0)
    );

    pfp_div #(.F(F), .TAG_W(1)) u_div1 (
        .aclk, .aresetn, .ce,
        .in_valid (r_valid),
        .in_num   (r_tag[T1_W+1+NORM_W +: NORM_W]),
        .in_den   (r_root),
        .in_tag   (r_tag[T1_W-2]),
        .out_valid(),
        .out_q    (d_q[1]),
        .out_tag  (d_tag1)
    );

    pfp_div #(.F(F), .TAG_W(1)) u_div2 (
        .aclk, .aresetn, .ce,
        .in_valid (r_valid),
        .in_num   (r_tag[T1_W+1+2*NORM_W +: NORM_W]),
        .in_den   (r_root),
        .in_tag   (r_tag[T1_W-1]),
        .out_valid(),
        .out_q    (d_q[2]),
        .out_tag  (d_tag2)
    );

    pfp_offset #(.CW(CW), .F(F)) u_offset (
        .aclk, .aresetn, .ce,
        .in_valid (d_valid),
        .in_q     (d_q),
        .in_neg   ({d_tag2[0], d_tag1[0], d_tag0[T1_W-3]}),
        .in_deg   (d_tag0[T1_W]),
        .in_p3    (d_tag0[3*CW-1:0]),
        .out_valid(m_axis_tvalid),
        .out_data (m_axis_tdata),
        .out_deg  (o_deg)
    );

    assign m_axis_tuser = o_deg;

endmodule

>>> hw/rtl/pfp_checker.sv
// ----------------------------------------------------------------------------
// pfp_checker
// Port-level checks for plane_from_three_points, bound to the top level.
// ----------------------------------------------------------------------------
module pfp_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,
    input  logic [pfp_pkg::IN_W-1:0]    s_axis_tdata,
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic [pfp_pkg::OUT_W-1:0]   m_axis_tdata,
    input  logic [0:0]                  m_axis_tuser
);
    import pfp_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // input side moves exactly when the output slot is free
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |-> s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("ready does not follow output slot");

    // collinear points give an all-zero result
    a_deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("degenerate result not zero");

    // a proper plane has a nonzero normal
    a_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[3*FIELD_W-1:0] != '0)
        else $error("zero normal on non-degenerate result");

endmodule

bind plane_from_three_points pfp_checker u_pfp_checker (.*);

>>> tb/plane_from_three_points_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// plane_from_three_points_checker
// Watches both stream channels of the plane block. It works out the unit
// normal, the plane offset and the collinear flag for every accepted point
// triple, queues them in order, and compares each result transfer field by
// field against the oldest queued plane.
// ----------------------------------------------------------------------------
module plane_from_three_points_checker (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_axis_tvalid,
    input  logic                      s_axis_tready,
    // p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z
    input  logic [pfp_pkg::IN_W-1:0]  s_axis_tdata,
    input  logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // normal_x, normal_y, normal_z, plane_offset
    input  logic [pfp_pkg::OUT_W-1:0] m_axis_tdata,
    // degenerate
    input  logic [0:0]                m_axis_tuser,
    output int                        fail_count,
    output int                        planes_pending
);
    localparam int FRAC = pfp_pkg::NORMAL_FRAC_BITS_DEF;
    localparam int CW   = pfp_pkg::COORD_WIDTH_DEF;

    typedef struct packed {
        logic [31:0] normal_x;
        logic [31:0] normal_y;
        logic [31:0] normal_z;
        logic [47:0] plane_offset;
        logic        degenerate;
    } plane_t;

    plane_t plane_queue[$];

    // exact plane through three points, normal rounded to FRAC fraction bits
    function automatic plane_t plane_predict(logic [pfp_pkg::IN_W-1:0] d);
        logic signed [127:0] pt[9];
        logic signed [127:0] v1[3];
        logic signed [127:0] v2[3];
        logic signed [127:0] cr[3];
        logic signed [127:0] nrm[3];
        logic signed [127:0] dot;
        logic [127:0] mag[3];
        logic [127:0] sum, root, trial, num, quo, rem, dmag, rnd;
        logic [127:0] offs;
        int bl, i, b;
        plane_t r;
        r = '0;
        for (i = 0; i < 9; i++) begin
            pt[i] = 128'(signed'(d[32*i +: CW]));
        end
        for (i = 0; i < 3; i++) begin
            v1[i] = pt[6+i] - pt[i];
            v2[i] = pt[3+i] - pt[i];
        end
        cr[0] = v1[1] * v2[2] - v1[2] * v2[1];
        cr[1] = v1[2] * v2[0] - v1[0] * v2[2];
        cr[2] = v1[0] * v2[1] - v1[1] * v2[0];
        // widest magnitude sets the common shift
        bl = 0;
        for (i = 0; i < 3; i++) begin
            mag[i] = cr[i] < 0 ? -cr[i] : cr[i];
            for (b = 0; b < 128; b++) begin
                if (mag[i][b] && b + 1 > bl) bl = b + 1;
            end
        end
        if (bl == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        for (i = 0; i < 3; i++) begin
            mag[i] = bl > 62 ? mag[i] >> (bl - 62) : mag[i] << (62 - bl);
        end
        sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        // floor square root, one bit at a time
        root = '0;
        for (b = 62; b >= 0; b--) begin
            trial = root | (128'd1 << b);
            if (trial * trial <= sum) root = trial;
        end
        // divide with ties away from zero
        for (i = 0; i < 3; i++) begin
            num = mag[i] << FRAC;
            quo = num / root;
            rem = num - quo * root;
            if (rem >= root - rem) quo = quo + 1;
            nrm[i] = cr[i] < 0 ? -$signed(quo) : $signed(quo);
        end
        dot = nrm[0] * pt[6] + nrm[1] * pt[7] + nrm[2] * pt[8];
        dmag = dot < 0 ? -dot : dot;
        rnd = (dmag + (128'd1 << (FRAC - 1))) >> FRAC;
        offs = dot >= 0 ? -rnd : rnd;
        r.normal_x = nrm[0][31:0];
        r.normal_y = nrm[1][31:0];
        r.normal_z = nrm[2][31:0];
        r.plane_offset = offs[47:0];
        return r;
    endfunction

    task automatic field_check(string fname, logic [47:0] exp_v, logic [47:0] act_v);
        if (exp_v !== act_v) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, exp_v, act_v);
        end
    endtask

    assign planes_pending = plane_queue.size();

    initial fail_count = 0;

    // queue on input transfers, compare on result transfers
    always @(posedge aclk) begin
        plane_t exp_p;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                plane_queue.push_back(plane_predict(s_axis_tdata));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (plane_queue.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result transfer, actual %h %b", $time,
                             m_axis_tdata, m_axis_tuser);
                end else begin
                    exp_p = plane_queue.pop_front();
                    field_check("normal_x", 48'(exp_p.normal_x), 48'(m_axis_tdata[31:0]));
                    field_check("normal_y", 48'(exp_p.normal_y), 48'(m_axis_tdata[63:32]));
                    field_check("normal_z", 48'(exp_p.normal_z), 48'(m_axis_tdata[95:64]));
                    field_check("plane_offset", exp_p.plane_offset, m_axis_tdata[143:96]);
                    field_check("degenerate", 48'(exp_p.degenerate), 48'(m_axis_tuser));
                end
            end
        end
    end

endmodule

>>> tb/plane_from_three_points_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// plane_from_three_points_tb
// Drives point triples into the plane block: a directed set of extreme,
// axis-aligned, collinear and coincident triangles, then random triples in
// three idle patterns with one long receiver hold-off. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module plane_from_three_points_tb;
    localparam int CYCLE_LIMIT = 400000;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    // p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z
    logic [pfp_pkg::IN_W-1:0]  s_axis_tdata = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    // normal_x, normal_y, normal_z, plane_offset
    logic [pfp_pkg::OUT_W-1:0] m_axis_tdata;
    // degenerate
    logic [0:0]                m_axis_tuser;

    int fail_count, planes_pending;
    int send_idle = 20;
    int recv_idle = 46;
    bit hold_request = 1'b0;
    int cycle_count = 0;

    always #5 aclk = ~aclk;

    plane_from_three_points dut (.*);

    plane_from_three_points_checker checker_inst (.*);

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("plane_from_three_points_tb: FAIL");
            $finish;
        end
    end

    // receiver: random stalls plus one long hold-off
    initial begin
        int hold_left;
        bit hold_taken;
        hold_left = 0;
        hold_taken = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready = 1'b0;
            end else begin
                m_axis_tready = $urandom_range(99) >= recv_idle;
            end
        end
    end

    // one triple transfer, with random idle cycles before it
    task automatic send_triple(logic [31:0] c[9]);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid = 1'b0;
            @(negedge aclk);
        end
        for (int i = 0; i < 9; i++) s_axis_tdata[32*i +: 32] = c[i];
        s_axis_tvalid = 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
    endtask

    // random triple: full range, small range, collinear or coincident
    task automatic send_random();
        logic [31:0] c[9];
        logic signed [31:0] dir[3];
        int kind, ka, kb;
        kind = $urandom_range(99);
        ka = $urandom_range(8) - 4;
        kb = $urandom_range(8) - 4;
        for (int i = 0; i < 9; i++) begin
            c[i] = kind < 45 ? $urandom : 32'($signed($urandom_range(4095)) - 2048) << 12;
        end
        if (kind >= 85) begin
            for (int i = 0; i < 3; i++) begin
                dir[i] = $signed($urandom_range(65535)) - 32768;
                c[3+i] = c[i] + ka * dir[i];
                c[6+i] = c[i] + (kind >= 95 ? 0 : kb) * dir[i];
            end
        end
        send_triple(c);
    endtask

    initial begin
        logic [31:0] c[9];
        logic [31:0] mx, mn;
        mx = 32'h7fffffff;
        mn = 32'h80000000;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: coincident, collinear, axis planes, extremes
        c = '{default: 32'h0};                                  send_triple(c);
        c = '{default: mx};                                     send_triple(c);
        c = '{default: mn};                                     send_triple(c);
        c = '{0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0};       send_triple(c);
        c = '{0, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000};       send_triple(c);
        c = '{0, 0, 0, 0, 0, 32'h10000, 32'h10000, 0, 0};       send_triple(c);
        c = '{1, 2, 3, 2, 4, 6, 3, 6, 9};                       send_triple(c);
        c = '{mn, mn, mn, mx, mx, mx, 0, 0, 0};                 send_triple(c);
        c = '{mn, mn, mn, mx, mn, mn, mn, mx, mn};              send_triple(c);
        c = '{mx, mx, mx, mn, mx, mx, mx, mn, mx};              send_triple(c);
        c = '{mn, mn, mx, mx, mn, mn, mn, mx, mn};              send_triple(c);
        c = '{mx, mn, mn, mn, mx, mn, mn, mn, mx};              send_triple(c);
        c = '{0, 0, 0, 1, 0, 0, 0, 1, 0};                       send_triple(c);
        c = '{0, 0, mx, 1, 0, mx, 0, 1, mx};                    send_triple(c);
        c = '{0, 0, mn, 1, 0, mn, 0, 1, mn};                    send_triple(c);
        c = '{5, 7, 11, 5, 8, 11, 6, 7, 12};                    send_triple(c);
        c = '{mx, 0, 0, 0, mx, 0, 0, 0, mx};                    send_triple(c);
        c = '{mn, 0, 0, 0, mn, 0, 0, 0, mn};                    send_triple(c);
        c = '{32'hffff0000, 3, 32'h00012345, 32'h7, 32'h10000,
              32'hfffe0000, 32'h20000, 32'hfff00001, 9};        send_triple(c);
        c = '{-1, -1, -1, 1, 1, 1, 3, 3, 3};                    send_triple(c);

        // random, three idle patterns
        repeat (620) send_random();
        send_idle = 46;
        recv_idle = 20;
        repeat (300) send_random();
        hold_request = 1'b1;
        repeat (320) send_random();
        send_idle = 0;
        recv_idle = 0;
        repeat (610) send_random();
        s_axis_tvalid = 1'b0;

        // drain, then let the pipeline settle
        while (planes_pending != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
        if (fail_count == 0) begin
            $display("plane_from_three_points_tb: PASS");
        end else begin
            $display("plane_from_three_points_tb: FAIL");
        end
        $finish;
    end

endmodule

>>> plane_from_three_points.f
hw/rtl/pfp_pkg.sv
hw/rtl/pfp_cross.sv
hw/rtl/pfp_norm.sv
hw/rtl/pfp_sqrt.sv
hw/rtl/pfp_div.sv
hw/rtl/pfp_offset.sv
hw/rtl/plane_from_three_points.sv
hw/rtl/pfp_checker.sv
tb/plane_from_three_points_checker.sv
tb/plane_from_three_points_tb.sv
